// File: rtl/quote_aware_whitespace_normalizer_macros.svh
// ----------------------------------------------------------------------------
// quote_aware_whitespace_normalizer_macros.svh
// Assertion macros shared by the normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef QUOTE_AWARE_WHITESPACE_NORMALIZER_MACROS_SVH
`define QUOTE_AWARE_WHITESPACE_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define QAWN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qawn assertion failed");

// Next-cycle implication, disabled during reset
`define QAWN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qawn assertion failed");

`endif

// File: rtl/qawn_pkg.sv
// ----------------------------------------------------------------------------
// qawn_pkg
// Types and constants of the quote-aware whitespace normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qawn_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CH_NUL    = 21'h00;
  localparam logic [CP_W-1:0] CH_TAB    = 21'h09;
  localparam logic [CP_W-1:0] CH_SPACE  = 21'h20;
  localparam logic [CP_W-1:0] CH_DQUOTE = 21'h22;
  localparam logic [CP_W-1:0] CH_SQUOTE = 21'h27;

  // Op queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_DOUBLE = 2'd1,
    QM_SINGLE = 2'd2
  } quote_mode_t;

  // One queued op: optional held space, then the character (or terminator)
  typedef struct packed {
    logic            add_space;
    logic [CP_W-1:0] ch;
    logic            last;
  } op_t;

  // Push side of the op queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } op_push_t;

  // Pop side of the op queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } op_head_t;

endpackage

`default_nettype wire

// File: rtl/qawn_in_if.sv
// ----------------------------------------------------------------------------
// qawn_in_if
// Input channel: one code point per beat, or the end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface qawn_in_if
  import qawn_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_end;

  modport source (output valid, output code_point, output is_end, input ready);
  modport sink   (input valid, input code_point, input is_end, output ready);
endinterface

`default_nettype wire

// File: rtl/qawn_out_if.sv
// ----------------------------------------------------------------------------
// qawn_out_if
// Output channel: one normalized character or the terminator per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface qawn_out_if
  import qawn_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] out_char;
  logic            is_last;

  modport source (output valid, output out_char, output is_last, input ready);
  modport sink   (input valid, input out_char, input is_last, output ready);
endinterface

`default_nettype wire

// File: rtl/quote_aware_whitespace_normalizer.sv
// ----------------------------------------------------------------------------
// quote_aware_whitespace_normalizer
// Collapses whitespace outside quotes, passes quoted text verbatim.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat payload               Last beat
// in       in   code_point[20:0], is_end   is_end = 1 (end marker)
// out      out  out_char[20:0], is_last    is_last = 1 (zero terminator)
//
// Input beats are taken one per cycle while the 4-entry op queue has room.
// Output gives one beat per cycle while the receiver is ready; a held space and
// its character become two output-sequencer beats, absorbed by the queue.
// An input beat passes through the op queue, then the output register.
// Reset (rst, synchronous) empties the queue and clears the quote state.
// Either side may stall independently; the queue and output register hold.
// ----------------------------------------------------------------------------
`default_nettype none

module quote_aware_whitespace_normalizer
  import qawn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  qawn_in_if.sink   in,
  qawn_out_if.source out
);

  op_push_t push;
  op_head_t head;
  logic     q_ready;
  logic     pop;

  qawn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in      (in),
    .q_ready (q_ready),
    .push    (push)
  );

  qawn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (q_ready),
    .head  (head),
    .pop   (pop)
  );

  qawn_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .out  (out)
  );

endmodule

`default_nettype wire

// File: rtl/qawn_front.sv
// ----------------------------------------------------------------------------
// qawn_front
// Accepts input beats, tracks quote/space state and queues output ops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quote_aware_whitespace_normalizer_macros.svh"

module qawn_front
  import qawn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  qawn_in_if.sink       in,
  input  wire logic     q_ready,
  output op_push_t      push
);

  quote_mode_t quote_mode, quote_mode_next;
  logic        seen_text, seen_text_next;
  logic        space_pending, space_pending_next;
  logic        accept;
  logic        is_blank;

  assign in.ready = q_ready;
  assign accept   = in.valid && in.ready;
  assign is_blank = (in.code_point == CH_SPACE) || (in.code_point == CH_TAB);

  // Classify the beat and build the op
  always_comb begin
    quote_mode_next    = quote_mode;
    seen_text_next     = seen_text;
    space_pending_next = space_pending;
    push.valid         = 1'b0;
    push.op.add_space  = 1'b0;
    push.op.ch         = in.code_point;
    push.op.last       = 1'b0;
    if (accept) begin
      if (in.is_end) begin
        push.valid         = 1'b1;
        push.op.ch         = CH_NUL;
        push.op.last       = 1'b1;
        quote_mode_next    = QM_NONE;
        seen_text_next     = 1'b0;
        space_pending_next = 1'b0;
      end else if (in.code_point == CH_NUL) begin
        // stray zero: dropped, no state change
      end else if (quote_mode == QM_DOUBLE || quote_mode == QM_SINGLE) begin
        // quoted text passes verbatim until the matching quote
        push.valid = 1'b1;
        if ((quote_mode == QM_DOUBLE && in.code_point == CH_DQUOTE) ||
            (quote_mode == QM_SINGLE && in.code_point == CH_SQUOTE)) begin
          quote_mode_next = QM_NONE;
        end
      end else if (is_blank) begin
        if (seen_text) begin
          space_pending_next = 1'b1;
        end
      end else begin
        push.valid         = 1'b1;
        push.op.add_space  = space_pending;
        space_pending_next = 1'b0;
        seen_text_next     = 1'b1;
        if (in.code_point == CH_DQUOTE) begin
          quote_mode_next = QM_DOUBLE;
        end else if (in.code_point == CH_SQUOTE) begin
          quote_mode_next = QM_SINGLE;
        end else begin
          quote_mode_next = QM_NONE;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode    <= QM_NONE;
      seen_text     <= 1'b0;
      space_pending <= 1'b0;
    end else begin
      quote_mode    <= quote_mode_next;
      seen_text     <= seen_text_next;
      space_pending <= space_pending_next;
    end
  end

  `QAWN_ASSERT_NXT(a_end_clears_state, clk, rst, accept && in.is_end,
    quote_mode == QM_NONE && !seen_text && !space_pending)
  `QAWN_ASSERT_IMP(a_pending_needs_text, clk, rst, space_pending, seen_text)
  `QAWN_ASSERT_IMP(a_no_pending_in_quote, clk, rst, quote_mode != QM_NONE,
    !space_pending)

endmodule

`default_nettype wire

// File: rtl/qawn_queue.sv
// ----------------------------------------------------------------------------
// qawn_queue
// Small op FIFO decoupling the classifier from the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module qawn_queue
  import qawn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire op_push_t push,
  output logic          ready,
  output op_head_t      head,
  input  wire logic     pop
);

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign ready     = (count != QCNT_W'(QUEUE_DEPTH));
  assign do_push   = push.valid && ready;
  assign do_pop    = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.op    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/qawn_back.sv
// ----------------------------------------------------------------------------
// qawn_back
// Expands queued ops into output beats through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quote_aware_whitespace_normalizer_macros.svh"

module qawn_back
  import qawn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire op_head_t head,
  output logic          pop,
  qawn_out_if.source    out
);

  logic            o_valid;
  logic [CP_W-1:0] o_char;
  logic            o_last;
  logic            space_done;
  logic            load;
  logic            send_space;

  assign out.valid    = o_valid;
  assign out.out_char = o_char;
  assign out.is_last  = o_last;

  // Load when an op is queued and the output register is free this cycle
  assign load       = head.valid && (!o_valid || out.ready);
  assign send_space = head.op.add_space && !space_done;
  assign pop        = load && !send_space;

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      o_char <= send_space ? CH_SPACE : head.op.ch;
      o_last <= send_space ? 1'b0 : head.op.last;
    end
  end

  // Output valid and space sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      space_done <= 1'b0;
    end else begin
      if (load) begin
        o_valid    <= 1'b1;
        space_done <= send_space;
      end else if (out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  `QAWN_ASSERT_IMP(a_space_done_has_head, clk, rst, space_done, head.valid)
  `QAWN_ASSERT_IMP(a_pop_has_head, clk, rst, pop, head.valid)
  `QAWN_ASSERT_IMP(a_last_not_split, clk, rst, o_valid && o_last, !space_done)

endmodule

`default_nettype wire

// File: tb/sv/quote_aware_whitespace_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quote_aware_whitespace_normalizer_tb
// Self-checking bench for the whitespace normalizer. Strings of code points,
// each closed by an end marker, go in through the input channel. A scoreboard
// keeps its own copy of the quote and spacing state, builds the expected
// characters for each accepted beat, and checks every output beat in order.
// Sender gaps and receiver stalls vary across the run.
// ----------------------------------------------------------------------------

import qawn_pkg::*;

typedef struct packed {
  logic [CP_W-1:0] ch;
  logic            last;
} norm_char_t;

class norm_scoreboard;
  quote_mode_t qmode;
  bit          seen_text;
  bit          space_held;
  norm_char_t  expected_chars[$];
  int          mismatches;
  int          chars_checked;

  function new();
    qmode         = QM_NONE;
    seen_text     = 1'b0;
    space_held    = 1'b0;
    mismatches    = 0;
    chars_checked = 0;
  endfunction

  function void push_char(logic [CP_W-1:0] ch, logic last);
    norm_char_t c;
    c.ch   = ch;
    c.last = last;
    expected_chars.push_back(c);
  endfunction

  // Note one accepted input beat and queue the characters it produces
  function void note_code_point(logic [CP_W-1:0] cp, logic fin);
    if (fin) begin
      push_char(CH_NUL, 1'b1);
      qmode      = QM_NONE;
      seen_text  = 1'b0;
      space_held = 1'b0;
      return;
    end
    // null without end flag is dropped with no state change
    if (cp == CH_NUL) return;

    // quoted text passes verbatim until the matching quote kind
    if (qmode == QM_DOUBLE || qmode == QM_SINGLE) begin
      push_char(cp, 1'b0);
      if ((qmode == QM_DOUBLE && cp == CH_DQUOTE) ||
          (qmode == QM_SINGLE && cp == CH_SQUOTE))
        qmode = QM_NONE;
      return;
    end

    // blanks only arm the held space once text has started
    if (cp == CH_SPACE || cp == CH_TAB) begin
      if (seen_text) space_held = 1'b1;
      return;
    end

    if (space_held) push_char(CH_SPACE, 1'b0);
    space_held = 1'b0;
    push_char(cp, 1'b0);
    seen_text = 1'b1;
    if (cp == CH_DQUOTE)      qmode = QM_DOUBLE;
    else if (cp == CH_SQUOTE) qmode = QM_SINGLE;
    else                      qmode = QM_NONE;
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Compare one output beat against the oldest expected character
  task check_char(logic [CP_W-1:0] ch, logic last);
    norm_char_t exp_c;
    chars_checked++;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected beat char=%06h last=%0b", ch, last));
      return;
    end
    exp_c = expected_chars.pop_front();
    if (ch !== exp_c.ch)
      report_mismatch($sformatf("out_char %06h, expected %06h", ch, exp_c.ch));
    if (last !== exp_c.last)
      report_mismatch($sformatf("is_last %0b, expected %0b", last, exp_c.last));
  endtask
endclass

module quote_aware_whitespace_normalizer_tb;
  import qawn_pkg::*;

  localparam int RANDOM_BEATS_PER_PHASE = 375;
  localparam int NUM_DIRECTED           = 23;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h1FFFFF;

  // {end flag, code point}
  localparam logic [CP_W:0] DIRECTED[NUM_DIRECTED] = '{
    // leading blanks, tab as space, collapsed run, trailing blanks dropped
    {1'b0, CH_SPACE}, {1'b0, CH_TAB}, {1'b0, 21'h61}, {1'b0, CH_SPACE},
    {1'b0, CH_TAB}, {1'b0, 21'h62}, {1'b0, CH_SPACE}, {1'b1, CH_NUL},
    // double quote holding blanks and a single quote, null ignored,
    // out-of-range code point, held space before a single quote,
    // single quote left open at the end marker
    {1'b0, 21'h71}, {1'b0, CH_SPACE}, {1'b0, CH_DQUOTE}, {1'b0, CH_SPACE},
    {1'b0, CH_SQUOTE}, {1'b0, CH_TAB}, {1'b0, CH_DQUOTE}, {1'b0, CH_NUL},
    {1'b0, CP_MAX}, {1'b0, CH_SPACE}, {1'b0, CH_SQUOTE}, {1'b0, CH_DQUOTE},
    {1'b0, CH_SPACE}, {1'b1, CP_MAX},
    // empty string
    {1'b1, CH_NUL}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  qawn_in_if  in_if();
  qawn_out_if out_if();

  quote_aware_whitespace_normalizer u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_if),
    .out (out_if)
  );

  norm_scoreboard sb;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int beats_sent    = 0;
  int nulls_sent    = 0;
  int strings_sent  = 0;

  always #1 clk = ~clk;

  // Receiver: ready changes on the falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      sb.check_char(out_if.out_char, out_if.is_last);
  end

  // Present one beat after a random gap, hold it until accepted
  task automatic send_beat(input logic [CP_W-1:0] cp, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.code_point <= cp;
    in_if.is_end     <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_code_point(cp, fin);
    if (fin) strings_sent++;
    else if (cp == CH_NUL) nulls_sent++;
    if (fin || cp != CH_NUL) beats_sent++;
  endtask

  // Weighted character mix: blanks, quotes, letters, extremes, noise
  function automatic logic [CP_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 20)      return CH_SPACE;
    else if (r < 30) return CH_TAB;
    else if (r < 40) return CH_DQUOTE;
    else if (r < 50) return CH_SQUOTE;
    else if (r < 78) return CP_W'(21'h61 + $urandom_range(25));
    else if (r < 81) return CH_NUL;
    else if (r < 84) return CP_MAX;
    else if (r < 86) return 21'h10FFFF;
    else             return CP_W'($urandom_range(CP_MAX, 1));
  endfunction

  // Random strings, each closed by an end marker, until the phase budget is met
  task automatic run_phase(input int src_pct, input int sink_pct);
    int start_beats;
    int len;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start_beats    = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS_PER_PHASE) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(24);
      repeat (len) send_beat(pick_char(), 1'b0);
      send_beat(CP_W'($urandom), 1'b1);
    end
  endtask

  initial begin
    sb = new();
    in_if.valid      = 1'b0;
    in_if.code_point = CH_NUL;
    in_if.is_end     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_beat(DIRECTED[i][CP_W-1:0], DIRECTED[i][CP_W]);

    run_phase(0, 0);
    run_phase(76, 0);
    run_phase(0, 76);
    run_phase(28, 28);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d strings, %0d input beats plus %0d nulls, over four idle mixes",
             strings_sent, beats_sent, nulls_sent);
    $display("Checked %0d output beats, %0d mismatches", sb.chars_checked,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Timeout waiting for output beats");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/qawn_pkg.sv
rtl/qawn_in_if.sv
rtl/qawn_out_if.sv
rtl/qawn_front.sv
rtl/qawn_queue.sv
rtl/qawn_back.sv
rtl/quote_aware_whitespace_normalizer.sv
tb/sv/quote_aware_whitespace_normalizer_tb.sv
